// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl; define NO_ASSERTIONS to drop them
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define BDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bdq assertion failed");

// next-cycle implication, disabled during reset
`define BDQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bdq assertion failed");

`else

`define BDQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BDQ_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/bdq_pkg.sv =====
// ---------------------------------------------------------------------------
// bdq_pkg
// types and constants of the bounded double-ended queue
// ---------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH    = 128;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int COUNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W    = 8;
	localparam int DATA_W   = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int CMP_W    = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

	localparam logic [OP_W-1:0] OP_PUSH_LEFT  = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH_RIGHT = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_LEFT   = 2'd2;
	localparam logic [OP_W-1:0] OP_POP_RIGHT  = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;      // capture the input transaction
		logic exec;      // perform the operation
		logic load_pop;  // capture the popped entry into the result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pop_ok;    // operation is a pop that will read the store
	} dp_sts_t;

endpackage

// ===== rtl/bdq_ctrl.sv =====
// ---------------------------------------------------------------------------
// bdq_ctrl
// sequencer: accept, execute, optional store read, respond
// ---------------------------------------------------------------------------
module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bdq_pkg::dp_sts_t  sts,
	output bdq_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done,
	output logic              cfg_ready
);

	bdq_pkg::state_t state_q;
	bdq_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bdq_pkg::S_IDLE: begin
				if (start) begin
					state_nxt = bdq_pkg::S_EXEC;
				end
			end
			bdq_pkg::S_EXEC: begin
				state_nxt = sts.pop_ok ? bdq_pkg::S_FETCH : bdq_pkg::S_RESP;
			end
			bdq_pkg::S_FETCH: begin
				state_nxt = bdq_pkg::S_RESP;
			end
			bdq_pkg::S_RESP: begin
				state_nxt = bdq_pkg::S_IDLE;
			end
			default: begin
				state_nxt = bdq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		busy      = 1'b1;
		done      = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			bdq_pkg::S_IDLE: begin
				busy      = 1'b0;
				cfg_ready = 1'b1;
				cmd.take  = start;
			end
			bdq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			bdq_pkg::S_FETCH: begin
				cmd.load_pop = 1'b1;
			end
			bdq_pkg::S_RESP: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/bdq_dpath.sv =====
// ---------------------------------------------------------------------------
// bdq_dpath
// end pointers, entry count, capacity register, entry store and result
// ---------------------------------------------------------------------------
module bdq_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bdq_pkg::dp_cmd_t                    cmd,
	output bdq_pkg::dp_sts_t                    sts,
	input  logic                                cfg_we,
	input  logic        [bdq_pkg::CAP_W-1:0]    cfg_data,
	input  logic        [bdq_pkg::OP_W-1:0]     op,
	input  logic signed [bdq_pkg::DATA_W-1:0]   push_value,
	output logic signed [bdq_pkg::DATA_W-1:0]   pop_value,
	output logic        [bdq_pkg::STATUS_W-1:0] status,
	output logic        [bdq_pkg::COUNT_W-1:0]  entry_count
);

	localparam logic [bdq_pkg::IDX_W-1:0] IDX_LAST = bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1);
	localparam logic [bdq_pkg::CMP_W-1:0] DEPTH_C  = bdq_pkg::CMP_W'(bdq_pkg::DEPTH);

	logic [bdq_pkg::CAP_W-1:0]    capacity_q;
	logic [bdq_pkg::IDX_W-1:0]    left_q;
	logic [bdq_pkg::IDX_W-1:0]    right_q;
	logic [bdq_pkg::COUNT_W-1:0]  held_q;
	logic [bdq_pkg::OP_W-1:0]     op_q;
	logic [bdq_pkg::DATA_W-1:0]   value_q;
	logic [bdq_pkg::DATA_W-1:0]   rdata_q;
	logic [bdq_pkg::DATA_W-1:0]   mem [bdq_pkg::DEPTH];
	logic [bdq_pkg::DATA_W-1:0]   res_pop_q;
	logic [bdq_pkg::STATUS_W-1:0] res_status_q;
	logic [bdq_pkg::COUNT_W-1:0]  res_count_q;

	logic [bdq_pkg::CMP_W-1:0]    cap_ext;
	logic [bdq_pkg::CMP_W-1:0]    limit;
	logic [bdq_pkg::CMP_W-1:0]    held_ext;
	logic                         is_push;
	logic                         full;
	logic                         empty;
	logic [bdq_pkg::IDX_W-1:0]    left_dec;
	logic [bdq_pkg::IDX_W-1:0]    left_inc;
	logic [bdq_pkg::IDX_W-1:0]    right_dec;
	logic [bdq_pkg::IDX_W-1:0]    right_inc;
	logic                         wr_en;
	logic [bdq_pkg::IDX_W-1:0]    wr_addr;
	logic [bdq_pkg::IDX_W-1:0]    rd_addr;
	logic                         rd_en;
	logic [bdq_pkg::COUNT_W-1:0]  count_nxt;
	logic [bdq_pkg::STATUS_W-1:0] status_nxt;

	// effective limit is the smaller of capacity and depth
	assign cap_ext  = bdq_pkg::CMP_W'(capacity_q);
	assign held_ext = bdq_pkg::CMP_W'(held_q);
	assign limit    = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;

	assign is_push = (op_q == bdq_pkg::OP_PUSH_LEFT) || (op_q == bdq_pkg::OP_PUSH_RIGHT);
	assign full    = held_ext >= limit;
	assign empty   = (held_q == '0);

	assign left_dec  = (left_q == '0) ? IDX_LAST : left_q - 1'b1;
	assign left_inc  = (left_q == IDX_LAST) ? '0 : left_q + 1'b1;
	assign right_dec = (right_q == '0) ? IDX_LAST : right_q - 1'b1;
	assign right_inc = (right_q == IDX_LAST) ? '0 : right_q + 1'b1;

	assign wr_en   = cmd.exec && is_push && !full;
	assign wr_addr = (op_q == bdq_pkg::OP_PUSH_LEFT) ? left_dec : right_q;
	assign rd_en   = cmd.exec && !is_push && !empty;
	assign rd_addr = (op_q == bdq_pkg::OP_POP_LEFT) ? left_q : right_dec;

	assign sts.pop_ok = !is_push && !empty;

	always_comb begin
		count_nxt  = held_q;
		status_nxt = bdq_pkg::STAT_DONE;
		if (is_push) begin
			if (full) begin
				status_nxt = bdq_pkg::STAT_FULL;
			end else begin
				count_nxt = held_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status_nxt = bdq_pkg::STAT_EMPTY;
			end else begin
				count_nxt = held_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bdq_pkg::CAP_RESET;
			left_q     <= '0;
			right_q    <= '0;
			held_q     <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			if (cmd.exec) begin
				held_q <= count_nxt;
				if (wr_en && (op_q == bdq_pkg::OP_PUSH_LEFT)) begin
					left_q <= left_dec;
				end
				if (wr_en && (op_q == bdq_pkg::OP_PUSH_RIGHT)) begin
					right_q <= right_inc;
				end
				if (rd_en && (op_q == bdq_pkg::OP_POP_LEFT)) begin
					left_q <= left_inc;
				end
				if (rd_en && (op_q == bdq_pkg::OP_POP_RIGHT)) begin
					right_q <= right_dec;
				end
			end
		end
	end

	// input capture and result registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= op;
			value_q <= push_value;
		end
		if (cmd.exec) begin
			res_pop_q    <= '0;
			res_status_q <= status_nxt;
			res_count_q  <= count_nxt;
		end
		if (cmd.load_pop) begin
			res_pop_q <= rdata_q;
		end
	end

	// entry store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value_q;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign pop_value   = res_pop_q;
	assign status      = res_status_q;
	assign entry_count = res_count_q;

endmodule

// ===== rtl/bounded_double_ended_queue_unit.sv =====
// ---------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// bounded deque of signed 32-bit values in a circular buffer with two end
// pointers; push/pop at either end, capacity set by a config register
// ---------------------------------------------------------------------------
//
// channel   handshake            payload
// --------  -------------------  ---------------------------------------
// request   start / busy         op, push_value
// result    done (1-cycle pulse) pop_value, status, entry_count
// config    cfg_valid/cfg_ready  capacity
//
// a request is taken on the edge where start is high and busy is low
// push or failed pop: the sequencer goes from exec to resp, where done pulses,
// then back to idle, where a new request can be taken
// successful pop: an extra fetch state for the registered read of the entry store
// comes between exec and resp
// reset clears pointers, count and sequencer; capacity returns to 128; the
// store needs no clearing since a pop only reads entries written before
// done is a strobe, the receiver cannot stall it
//
`include "assert_macros.svh"

module bounded_double_ended_queue_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// request
	input  logic                                start,
	output logic                                busy,
	input  logic        [bdq_pkg::OP_W-1:0]     op,
	input  logic signed [bdq_pkg::DATA_W-1:0]   push_value,
	// result
	output logic                                done,
	output logic signed [bdq_pkg::DATA_W-1:0]   pop_value,
	output logic        [bdq_pkg::STATUS_W-1:0] status,
	output logic        [bdq_pkg::COUNT_W-1:0]  entry_count,
	// config
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [bdq_pkg::CAP_W-1:0]    capacity
);

	bdq_pkg::dp_cmd_t cmd;
	bdq_pkg::dp_sts_t sts;
	logic             cfg_we;

	// config transaction only while idle
	assign cfg_we = cfg_valid && cfg_ready;

	// sequencer
	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.cfg_ready (cfg_ready)
	);

	// pointers, count, store and result registers
	bdq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_data    (capacity),
		.op          (op),
		.push_value  (push_value),
		.pop_value   (pop_value),
		.status      (status),
		.entry_count (entry_count)
	);

	// an accepted request makes the unit busy in the next cycle
	`BDQ_ASSERT_NXT(a_take_busy, clk, arst_n, start && !busy, busy)

	// result strobe lasts a single cycle and the unit is idle after it
	`BDQ_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done && !busy)

	// reported count never exceeds the store depth
	`BDQ_ASSERT_IMP(a_count_range, clk, arst_n, done,
		entry_count <= bdq_pkg::COUNT_W'(bdq_pkg::DEPTH))

	// failed operations return a zero value
	`BDQ_ASSERT_IMP(a_fail_zero, clk, arst_n,
		done && (status != bdq_pkg::STAT_DONE), pop_value == '0)

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// testbench for the bounded double-ended queue: a queue-fed driver issues
// push/pop requests, a shadow deque predicts every result and a monitor
// compares each done strobe against the oldest prediction
// ---------------------------------------------------------------------------
module tb;

	localparam logic [bdq_pkg::IDX_W-1:0] IDX_LAST = bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1);

	// one request as queued for the driver, with the idle cycles before it
	typedef struct {
		logic [bdq_pkg::OP_W-1:0]          kind;
		logic signed [bdq_pkg::DATA_W-1:0] value;
		int unsigned                       gap;
	} deque_request_t;

	// one predicted result transaction
	typedef struct {
		logic signed [bdq_pkg::DATA_W-1:0] pop_value;
		logic [bdq_pkg::STATUS_W-1:0]      status;
		logic [bdq_pkg::COUNT_W-1:0]       count;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                              start = 1'b0;
	logic                              busy;
	logic [bdq_pkg::OP_W-1:0]          op = bdq_pkg::OP_PUSH_LEFT;
	logic signed [bdq_pkg::DATA_W-1:0] push_value = '0;
	logic                              done;
	logic signed [bdq_pkg::DATA_W-1:0] pop_value;
	logic [bdq_pkg::STATUS_W-1:0]      status;
	logic [bdq_pkg::COUNT_W-1:0]       entry_count;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [bdq_pkg::CAP_W-1:0]         capacity = bdq_pkg::CAP_RESET;

	// requests waiting for the driver, results waiting for the monitor
	deque_request_t pending_requests[$];
	deque_result_t  expected_results[$];

	// shadow copy of the deque contents, pointers and capacity register
	logic signed [bdq_pkg::DATA_W-1:0] shadow_store[bdq_pkg::DEPTH];
	logic [bdq_pkg::IDX_W-1:0]         shadow_left = '0;
	logic [bdq_pkg::IDX_W-1:0]         shadow_right = '0;
	int unsigned                       shadow_held = 0;
	int unsigned                       shadow_capacity = 32'(bdq_pkg::CAP_RESET);

	int unsigned idle_cycles = 0;
	int unsigned fail_count = 0;

	bounded_double_ended_queue_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.push_value  (push_value),
		.done        (done),
		.pop_value   (pop_value),
		.status      (status),
		.entry_count (entry_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.capacity    (capacity)
	);

	always #1 clk = ~clk;

	// applies one operation to the shadow deque and returns its result
	function automatic deque_result_t deque_apply(input logic [bdq_pkg::OP_W-1:0] kind,
			input logic signed [bdq_pkg::DATA_W-1:0] value);
		deque_result_t r;
		int unsigned limit;
		r.pop_value = '0;
		r.status = bdq_pkg::STAT_DONE;
		// capacity above the store size is clipped to the store size
		limit = (shadow_capacity > bdq_pkg::DEPTH) ? bdq_pkg::DEPTH : shadow_capacity;
		if (kind == bdq_pkg::OP_PUSH_LEFT || kind == bdq_pkg::OP_PUSH_RIGHT) begin
			// also covers capacity lowered under the current count
			if (shadow_held >= limit) begin
				r.status = bdq_pkg::STAT_FULL;
			end else if (kind == bdq_pkg::OP_PUSH_LEFT) begin
				shadow_left = (shadow_left == '0) ? IDX_LAST : shadow_left - 1'b1;
				shadow_store[shadow_left] = value;
				shadow_held++;
			end else begin
				shadow_store[shadow_right] = value;
				shadow_right = (shadow_right == IDX_LAST) ? '0 : shadow_right + 1'b1;
				shadow_held++;
			end
		end else begin
			if (shadow_held == 0) begin
				r.status = bdq_pkg::STAT_EMPTY;
			end else if (kind == bdq_pkg::OP_POP_LEFT) begin
				r.pop_value = shadow_store[shadow_left];
				shadow_left = (shadow_left == IDX_LAST) ? '0 : shadow_left + 1'b1;
				shadow_held--;
			end else begin
				shadow_right = (shadow_right == '0) ? IDX_LAST : shadow_right - 1'b1;
				r.pop_value = shadow_store[shadow_right];
				shadow_held--;
			end
		end
		r.count = bdq_pkg::COUNT_W'(shadow_held);
		return r;
	endfunction

	function automatic void flag_error(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR at %0t: %s", $realtime, what);
	endfunction

	// request driver: a transaction is taken where start is high and busy low;
	// the gap of the next request counts only cycles where the block is free
	always @(posedge clk or negedge arst_n) begin : request_driver
		deque_request_t item;
		logic taken;
		if (!arst_n) begin
			start <= 1'b0;
			op <= bdq_pkg::OP_PUSH_LEFT;
			push_value <= '0;
			idle_cycles = 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				expected_results.push_back(deque_apply(op, push_value));
				idle_cycles = 0;
			end
			if (!start || taken) begin
				if (pending_requests.size() > 0 && idle_cycles >= pending_requests[0].gap) begin
					// start stays high when the next request follows back to back
					item = pending_requests.pop_front();
					start <= 1'b1;
					op <= item.kind;
					push_value <= item.value;
				end else begin
					start <= 1'b0;
					if (!busy && !taken)
						idle_cycles++;
				end
			end
		end
	end

	// result monitor: done is a one-cycle strobe, no back-pressure possible
	always @(posedge clk) begin : result_monitor
		deque_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				flag_error($sformatf("unexpected result: pop_value %0d status %0d count %0d",
					pop_value, status, entry_count));
			end else begin
				want = expected_results.pop_front();
				if (pop_value !== want.pop_value || status !== want.status
						|| entry_count !== want.count)
					flag_error($sformatf({"result mismatch: expected pop_value %0d status %0d ",
						"count %0d, got pop_value %0d status %0d count %0d"},
						want.pop_value, want.status, want.count,
						pop_value, status, entry_count));
			end
		end
	end

	task automatic add_request(input logic [bdq_pkg::OP_W-1:0] kind,
			input logic signed [bdq_pkg::DATA_W-1:0] value, input int unsigned gap);
		deque_request_t item;
		item.kind = kind;
		item.value = value;
		item.gap = gap;
		pending_requests.push_back(item);
	endtask

	// random requests; push_pct sets the fill/drain bias, gap_max the idling
	task automatic add_random(input int unsigned n, input int unsigned push_pct,
			input int unsigned gap_max);
		logic [bdq_pkg::OP_W-1:0] kind;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(99) < push_pct)
				kind = $urandom_range(1) ? bdq_pkg::OP_PUSH_RIGHT : bdq_pkg::OP_PUSH_LEFT;
			else
				kind = $urandom_range(1) ? bdq_pkg::OP_POP_RIGHT : bdq_pkg::OP_POP_LEFT;
			add_request(kind, $urandom, $urandom_range(gap_max));
		end
	endtask

	// block is idle once every request is taken and every result is back
	task automatic wait_quiet();
		do @(negedge clk);
		while (pending_requests.size() != 0 || start || busy || expected_results.size() != 0);
	endtask

	task automatic write_capacity(input logic [bdq_pkg::CAP_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		capacity <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_capacity = 32'(value);
		@(negedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: pops on an empty deque, extreme values at both ends
		add_request(bdq_pkg::OP_POP_LEFT, 32'sh7fff_ffff, 0);
		add_request(bdq_pkg::OP_POP_RIGHT, 32'sh8000_0000, 0);
		add_request(bdq_pkg::OP_PUSH_LEFT, 32'sh7fff_ffff, $urandom_range(3));
		add_request(bdq_pkg::OP_PUSH_RIGHT, 32'sh8000_0000, 0);
		add_request(bdq_pkg::OP_PUSH_LEFT, -32'sd1, $urandom_range(3));
		add_request(bdq_pkg::OP_PUSH_RIGHT, 32'sd0, 0);
		// pops ignore push_value, so hand them garbage
		add_request(bdq_pkg::OP_POP_LEFT, $urandom, $urandom_range(3));
		add_request(bdq_pkg::OP_POP_RIGHT, $urandom, 0);
		add_request(bdq_pkg::OP_POP_RIGHT, $urandom, 0);
		add_request(bdq_pkg::OP_POP_LEFT, $urandom, $urandom_range(3));
		add_request(bdq_pkg::OP_POP_LEFT, -32'sd1, 0);
		add_request(bdq_pkg::OP_PUSH_RIGHT, 32'sh5555_aaaa, 0);
		add_request(bdq_pkg::OP_POP_LEFT, 32'sd0, 0);
		wait_quiet();

		// capacity zero: every push is full, pops see an empty deque
		write_capacity(bdq_pkg::CAP_W'(0));
		add_request(bdq_pkg::OP_PUSH_LEFT, $urandom, 0);
		add_request(bdq_pkg::OP_PUSH_RIGHT, $urandom, $urandom_range(3));
		add_request(bdq_pkg::OP_POP_LEFT, $urandom, 0);
		add_request(bdq_pkg::OP_POP_RIGHT, $urandom, 0);
		wait_quiet();

		// capacity above the store size, fill all the way to full
		write_capacity(bdq_pkg::CAP_W'(255));
		add_random(220, 85, 3);
		wait_quiet();

		// capacity dropped below the count, drain back under it
		write_capacity(bdq_pkg::CAP_W'(100));
		add_random(100, 30, 3);
		wait_quiet();

		// exact store size, back-to-back requests with no idling
		write_capacity(bdq_pkg::CAP_RESET);
		add_random(100, 50, 0);
		wait_quiet();

		// capacity one: drain, then bounce between empty and full
		write_capacity(bdq_pkg::CAP_W'(1));
		add_random(120, 10, 3);
		wait_quiet();

		write_capacity(bdq_pkg::CAP_W'(4));
		add_random(80, 50, 3);
		wait_quiet();

		// let a stray strobe show up before the verdict
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#200000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bdq_pkg.sv
rtl/bdq_ctrl.sv
rtl/bdq_dpath.sv
rtl/bounded_double_ended_queue_unit.sv
sim/tb.sv
